// ===== rtl/mss_pkg.sv =====
// Shared types, constants and helpers of the mission state supervisor.
package mss_pkg;

  localparam int STATE_W   = 4;
  localparam int CNT_W     = 32;
  localparam int BUDGET_W  = 31;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_BUDGETS = 8;
  localparam int IDX_W     = 4;
  localparam int MOVE_W    = 9;
  localparam int CAUSE_W   = 8;
  localparam int ELAPSED_W = 24;
  localparam int NUM_STATES = 15;

  localparam logic [STATE_W-1:0] STATE_BOOT     = 4'd0;
  localparam logic [STATE_W-1:0] FIRST_POLICED  = 4'd2;
  localparam logic [STATE_W-1:0] LAST_POLICED   = 4'd9;
  localparam logic [STATE_W-1:0] STATE_DETECTOR = 4'd7;
  localparam logic [STATE_W-1:0] STATE_TIER1    = 4'd8;
  localparam logic [STATE_W-1:0] STATE_LIMIT    = 4'd15;

  // Bit t of row f marks f -> t as a legal move.
  localparam logic [15:0] LEGAL_TO [NUM_STATES] = '{
    16'h0003, 16'h0004, 16'h000C, 16'h0018, 16'h0038, 16'h0060, 16'h00D0, 16'h0178,
    16'h0A00, 16'h4800, 16'h0000, 16'h107C, 16'h2000, 16'h2000, 16'h0008
  };
  // Bit t of row f marks f -> t as a return to an earlier stage.
  localparam logic [15:0] REENTRY_TO [NUM_STATES] = '{
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0008, 16'h0000, 16'h0010, 16'h0078,
    16'h0000, 16'h0000, 16'h0000, 16'h007C, 16'h0000, 16'h0000, 16'h0008
  };

  typedef enum logic [2:0] {
    MODE_REQUEST   = 3'd0,
    MODE_TICK      = 3'd1,
    MODE_TERMINATE = 3'd2,
    MODE_PAYLOAD   = 3'd3,
    MODE_QUERY     = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_PARAM    = 2'd1,
    STATUS_STATE    = 2'd2,
    STATUS_NO_ENTRY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FAULT_NONE       = 2'd0,
    FAULT_ILLEGAL    = 2'd1,
    FAULT_TIMEOUT    = 2'd2,
    FAULT_TERMINATED = 2'd3
  } fault_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [STATE_W-1:0] target_state;
    logic [CAUSE_W-1:0] fault_cause;
    logic               payload_value;
    logic [IDX_W-1:0]   history_index;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         fault_kind;
    logic [31:0]        fault_detail;
    logic               reentry_note;
    logic [STATE_W-1:0] current_state;
    logic               payload_operational;
    logic               terminated;
    logic [CNT_W-1:0]   entry_count;
    logic [CNT_W-1:0]   reentry_total;
    logic [CNT_W-1:0]   rejection_total;
    logic [CNT_W-1:0]   history_time;
    logic [MOVE_W-1:0]  history_entry;
  } out_t;

  typedef struct packed {
    logic              en;
    logic [CNT_W-1:0]  stamp;
    logic [MOVE_W-1:0] move;
  } hist_wr_t;

  typedef struct packed {
    logic              hit;
    logic [CNT_W-1:0]  stamp;
    logic [MOVE_W-1:0] move;
  } hist_rd_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

// ===== rtl/mss_if.sv =====
// Channel interfaces of the mission state supervisor: input, result and configuration.
interface mss_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [3:0] target_state;
  logic [7:0] fault_cause;
  logic       payload_value;
  logic [3:0] history_index;

  modport source (output valid, mode, target_state, fault_cause, payload_value,
                  history_index, input ready);
  modport sink   (input valid, mode, target_state, fault_cause, payload_value,
                  history_index, output ready);
endinterface

interface mss_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  fault_kind;
  logic [31:0] fault_detail;
  logic        reentry_note;
  logic [3:0]  current_state;
  logic        payload_operational;
  logic        terminated;
  logic [31:0] entry_count;
  logic [31:0] reentry_total;
  logic [31:0] rejection_total;
  logic [31:0] history_time;
  logic [8:0]  history_entry;

  modport source (output valid, status, fault_kind, fault_detail, reentry_note,
                  current_state, payload_operational, terminated, entry_count,
                  reentry_total, rejection_total, history_time, history_entry,
                  input ready);
  modport sink   (input valid, status, fault_kind, fault_detail, reentry_note,
                  current_state, payload_operational, terminated, entry_count,
                  reentry_total, rejection_total, history_time, history_entry,
                  output ready);
endinterface

interface mss_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [30:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/mss_hist.sv =====
// History ring of accepted transitions: write pointer, fill level and a forwarded read port.
module mss_hist #(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mss_pkg::hist_wr_t wr,
  input  logic              rd_en,
  input  logic [3:0]        rd_idx,
  output mss_pkg::hist_rd_t rd
);
  import mss_pkg::*;

  localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam int AW = (PW + 1 > IDX_W) ? PW + 1 : IDX_W + 1;
  localparam int CW = (FW > IDX_W) ? FW : IDX_W;
  localparam int EW = CNT_W + MOVE_W;

  logic [EW-1:0] ring_mem [HISTORY_DEPTH];

  logic [PW-1:0] wp_r, wp_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] slot_sum;
  logic [PW-1:0] rd_addr;
  logic          hit;
  logic [EW-1:0] mem_q_r, fwd_q_r;
  logic          fwd_r, hit_r;

  always_comb begin
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    if (wr.en) begin
      wp_nxt = (wp_r == PW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (fill_r != FW'(HISTORY_DEPTH)) fill_nxt = fill_r + 1'b1;
    end
    // Most recent entry sits just below the pointer that the beat ahead leaves.
    slot_sum = AW'(wp_nxt) + AW'(HISTORY_DEPTH - 1) - AW'(rd_idx);
    if (slot_sum >= AW'(HISTORY_DEPTH)) slot_sum = slot_sum - AW'(HISTORY_DEPTH);
    rd_addr = slot_sum[PW-1:0];
    hit     = CW'(rd_idx) < CW'(fill_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) ring_mem[wp_r] <= {wr.stamp, wr.move};
    if (rd_en) begin
      mem_q_r <= ring_mem[rd_addr];
      fwd_r   <= wr.en && (wp_r == rd_addr);
      fwd_q_r <= {wr.stamp, wr.move};
      hit_r   <= hit;
    end
  end

  always_comb begin
    rd.hit = hit_r;
    {rd.stamp, rd.move} = fwd_r ? fwd_q_r : mem_q_r;
  end

endmodule

// ===== rtl/mission_state_supervisor.sv =====
// Mission state supervisor top level: checks moves, polices budgets, keeps counters and history.
//
//   channel  | dir | handshake       | beat carries
//   in_bus   | in  | valid / ready   | mode, target_state, fault_cause, payload_value, index
//   out_bus  | out | valid / ready   | status, fault report, state, counters, history entry
//   cfg_bus  | in  | valid / ready=1 | budget register index and 31-bit value
//
// One beat per cycle while out_bus accepts results; each beat first does the entry count
// and history memory reads, then the table check, update and write back.
// A write to the entry being read by the next beat is forwarded from a bypass register.
// rst_n is synchronous; the history ring is not cleared and needs no clearing pass.
// A stalled result register holds the beat behind it, and in_bus stalls only then.
module mission_state_supervisor #(
  parameter int HISTORY_DEPTH = 16
) (
  input logic clk,
  input logic rst_n,
  mss_in_if.sink    in_bus,
  mss_out_if.source out_bus,
  mss_cfg_if.sink   cfg_bus
);
  import mss_pkg::*;

  // Pipeline control
  logic in_ready, in_fire, s1_fire;
  logic s1_valid_r, out_valid_r;
  in_t  s1_q_r;
  out_t out_q_r, out_nxt;

  // Architectural state
  logic [BUDGET_W-1:0] budget_r [NUM_BUDGETS];
  logic [STATE_W-1:0]  pstate_r, pstate_nxt;
  logic [CNT_W-1:0]    elapsed_r, elapsed_nxt;
  logic                tflag_r, tflag_nxt;
  logic                payload_r, payload_nxt;
  logic                ended_r, ended_nxt;
  logic [CAUSE_W-1:0]  cause_r, cause_nxt;
  logic [CNT_W-1:0]    reent_r, reent_nxt;
  logic [CNT_W-1:0]    rej_r, rej_nxt;
  logic [CNT_W-1:0]    stamp_r, stamp_nxt;

  // Entry count memory with valid bits standing in for its reset values
  logic [CNT_W-1:0]      cnt_mem [NUM_STATES];
  logic [NUM_STATES-1:0] cnt_vld_r;
  logic [CNT_W-1:0]      cnt_q_r, cnt_fwd_q_r;
  logic                  cnt_fwd_r;
  logic                  cnt_wr_en;
  logic [CNT_W-1:0]      cnt_cur, cnt_new;

  hist_wr_t hist_wr;
  hist_rd_t hist_rd;

  logic               to_ok, legal, reent;
  logic [STATE_W-1:0] bidx;
  logic [CNT_W-1:0]   el_sat;
  logic [BUDGET_W-1:0] budget;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_bus.valid && in_ready;
  assign in_bus.ready  = in_ready;
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) s1_valid_r <= 1'b1;
      else if (s1_fire) s1_valid_r <= 1'b0;
      if (s1_fire) out_valid_r <= 1'b1;
      else if (out_bus.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_q_r <= '{mode: in_bus.mode, target_state: in_bus.target_state,
                  fault_cause: in_bus.fault_cause, payload_value: in_bus.payload_value,
                  history_index: in_bus.history_index};
    end
    if (s1_fire) out_q_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUDGETS; i++) budget_r[i] <= '0;
    end else if (cfg_bus.valid) begin
      budget_r[cfg_bus.index] <= cfg_bus.data;
    end
  end

  // Entry count reads go out at acceptance; the beat ahead may write the same entry then.
  always_ff @(posedge clk) begin
    if (cnt_wr_en) cnt_mem[s1_q_r.target_state] <= cnt_new;
    if (in_fire) begin
      if (in_bus.target_state != STATE_LIMIT) cnt_q_r <= cnt_mem[in_bus.target_state];
      cnt_fwd_r   <= cnt_wr_en && (s1_q_r.target_state == in_bus.target_state);
      cnt_fwd_q_r <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_vld_r <= '0;
    else if (cnt_wr_en) cnt_vld_r[s1_q_r.target_state] <= 1'b1;
  end

  mss_hist #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (hist_wr),
    .rd_en  (in_fire),
    .rd_idx (in_bus.history_index),
    .rd     (hist_rd)
  );

  always_comb begin
    to_ok = s1_q_r.target_state != STATE_LIMIT;
    legal = LEGAL_TO[pstate_r][s1_q_r.target_state];
    reent = REENTRY_TO[pstate_r][s1_q_r.target_state];
    bidx  = pstate_r - FIRST_POLICED;
    budget = budget_r[bidx[CFG_IDX_W-1:0]];
    el_sat = sat_inc(elapsed_r);

    if (cnt_fwd_r) cnt_cur = cnt_fwd_q_r;
    else if (to_ok && cnt_vld_r[s1_q_r.target_state]) cnt_cur = cnt_q_r;
    else cnt_cur = (s1_q_r.target_state == STATE_BOOT) ? CNT_W'(1) : '0;
    cnt_new = sat_inc(cnt_cur);

    pstate_nxt  = pstate_r;
    elapsed_nxt = elapsed_r;
    tflag_nxt   = tflag_r;
    payload_nxt = payload_r;
    ended_nxt   = ended_r;
    cause_nxt   = cause_r;
    reent_nxt   = reent_r;
    rej_nxt     = rej_r;
    stamp_nxt   = stamp_r;
    cnt_wr_en   = 1'b0;
    hist_wr     = '{en: 1'b0, stamp: stamp_r,
                    move: {pstate_r, s1_q_r.target_state, reent}};
    out_nxt     = '0;
    out_nxt.status     = STATUS_OK;
    out_nxt.fault_kind = FAULT_NONE;

    unique case (s1_q_r.mode)
      MODE_REQUEST: begin
        if (!to_ok) begin
          rej_nxt = sat_inc(rej_r);
          out_nxt.status       = STATUS_PARAM;
          out_nxt.fault_kind   = FAULT_ILLEGAL;
          out_nxt.fault_detail = {28'd0, s1_q_r.target_state};
        end else if (ended_r) begin
          rej_nxt = sat_inc(rej_r);
          out_nxt.status = STATUS_STATE;
        end else if (!legal) begin
          rej_nxt = sat_inc(rej_r);
          out_nxt.status       = STATUS_STATE;
          out_nxt.fault_kind   = FAULT_ILLEGAL;
          out_nxt.fault_detail = {20'd0, pstate_r, 4'd0, s1_q_r.target_state};
        end else begin
          pstate_nxt  = s1_q_r.target_state;
          elapsed_nxt = '0;
          tflag_nxt   = 1'b0;
          cnt_wr_en   = s1_fire;
          hist_wr.en  = s1_fire;
          if (reent) begin
            reent_nxt = sat_inc(reent_r);
            out_nxt.reentry_note = 1'b1;
          end
          // Leaving detector enable for the first tier declares the payload.
          if (pstate_r == STATE_DETECTOR && s1_q_r.target_state == STATE_TIER1) begin
            payload_nxt = 1'b1;
          end
        end
      end
      MODE_TICK: begin
        stamp_nxt   = stamp_r + 1'b1;
        elapsed_nxt = el_sat;
        if (!ended_r && pstate_r >= FIRST_POLICED && pstate_r <= LAST_POLICED &&
            budget != '0 && el_sat > {1'b0, budget} && !tflag_r) begin
          tflag_nxt = 1'b1;
          out_nxt.fault_kind   = FAULT_TIMEOUT;
          out_nxt.fault_detail = {4'd0, pstate_r, el_sat[ELAPSED_W-1:0]};
        end
      end
      MODE_TERMINATE: begin
        if (!ended_r) begin
          ended_nxt   = 1'b1;
          cause_nxt   = s1_q_r.fault_cause;
          payload_nxt = 1'b0;
          out_nxt.fault_kind   = FAULT_TERMINATED;
          out_nxt.fault_detail = {28'd0, pstate_r};
        end
      end
      MODE_PAYLOAD: begin
        payload_nxt = s1_q_r.payload_value;
      end
      MODE_QUERY: begin
        out_nxt.fault_detail = {24'd0, cause_r};
        if (!hist_rd.hit) begin
          out_nxt.status = STATUS_NO_ENTRY;
        end else begin
          out_nxt.history_time  = hist_rd.stamp;
          out_nxt.history_entry = hist_rd.move;
        end
      end
      default: begin
        out_nxt.status = STATUS_PARAM;
      end
    endcase

    out_nxt.current_state       = pstate_nxt;
    out_nxt.payload_operational = payload_nxt;
    out_nxt.terminated          = ended_nxt;
    out_nxt.entry_count         = !to_ok ? '0 : (cnt_wr_en ? cnt_new : cnt_cur);
    out_nxt.reentry_total       = reent_nxt;
    out_nxt.rejection_total     = rej_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pstate_r  <= STATE_BOOT;
      elapsed_r <= '0;
      tflag_r   <= 1'b0;
      payload_r <= 1'b0;
      ended_r   <= 1'b0;
      cause_r   <= '0;
      reent_r   <= '0;
      rej_r     <= '0;
      stamp_r   <= '0;
    end else if (s1_fire) begin
      pstate_r  <= pstate_nxt;
      elapsed_r <= elapsed_nxt;
      tflag_r   <= tflag_nxt;
      payload_r <= payload_nxt;
      ended_r   <= ended_nxt;
      cause_r   <= cause_nxt;
      reent_r   <= reent_nxt;
      rej_r     <= rej_nxt;
      stamp_r   <= stamp_nxt;
    end
  end

  assign out_bus.valid               = out_valid_r;
  assign out_bus.status              = out_q_r.status;
  assign out_bus.fault_kind          = out_q_r.fault_kind;
  assign out_bus.fault_detail        = out_q_r.fault_detail;
  assign out_bus.reentry_note        = out_q_r.reentry_note;
  assign out_bus.current_state       = out_q_r.current_state;
  assign out_bus.payload_operational = out_q_r.payload_operational;
  assign out_bus.terminated          = out_q_r.terminated;
  assign out_bus.entry_count         = out_q_r.entry_count;
  assign out_bus.reentry_total       = out_q_r.reentry_total;
  assign out_bus.rejection_total     = out_q_r.rejection_total;
  assign out_bus.history_time        = out_q_r.history_time;
  assign out_bus.history_entry       = out_q_r.history_entry;

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted beat did not reach the update stage");

  a_timeout_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(tflag_r) |-> $past(s1_fire) && $past(s1_q_r.mode) == MODE_TICK)
    else $error("timeout flag set without a tick");

  a_ended_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(ended_r) |-> ended_r)
    else $error("terminated flag cleared");

  a_rejections_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> rej_r >= $past(rej_r))
    else $error("rejection counter went down");

  a_state_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && cnt_wr_en |-> to_ok && legal && !ended_r)
    else $error("entry count written for a refused move");

endmodule
